@@ sv/sukt_pkg.sv @@
// ============================================================================
// sukt_pkg
// Shared types and constants for the sorted unique-key record table.
// ============================================================================
package sukt_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_INSERT = 2'd0;
    localparam cmd_t CMD_REMOVE = 2'd1;
    localparam cmd_t CMD_LOOKUP = 2'd2;
    localparam cmd_t CMD_UNUSED = 2'd3;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_DUP  = 2'd1;
    localparam status_t ST_FULL = 2'd2;
    localparam status_t ST_MISS = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_DONE
    } state_t;

endpackage

@@ sv/sorted_unique_key_table.sv @@
// ============================================================================
// sorted_unique_key_table
// Record table kept in ascending signed key order, with insert, remove and
// lookup commands, held in a pair of synchronous memories with one read and one write port.
// ============================================================================
// Steps: a read and a compare state per entry scanned, up to the first key not
// below the searched key, a decide state, a read and a write state per record
// moved, a state to place a new record, and a state to post the result. A new
// word is taken only in the idle state, so one item is finished before the next
// is accepted. The next word is taken while a result waits.
// Reset clears the record count and the control state; memories are not cleared.
module sorted_unique_key_table #(
    parameter int CAPACITY = sukt_pkg::DEFAULT_CAPACITY
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata fields from bit 0 up: command[1:0], key[33:2], payload[65:34].
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sukt_pkg::IN_TDATA_W-1:0]    s_tdata,
    // m_tdata fields from bit 0 up: status[1:0], found_payload[33:2],
    // entry_count[40:34].
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sukt_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    import sukt_pkg::*;

    // The address needs one bit at least; the count must also hold CAPACITY.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Record memories. Both are read and written at the same address each
    // cycle, so key and payload of an entry always travel together.
    logic [KEY_W-1:0]     key_mem [CAPACITY];
    logic [PAYLOAD_W-1:0] pay_mem [CAPACITY];

    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_W-1:0]     wr_key;
    logic [PAYLOAD_W-1:0] wr_pay;
    logic signed [KEY_W-1:0] key_q;
    logic [PAYLOAD_W-1:0] pay_q;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            pay_mem[wr_addr] <= wr_pay;
        end
        key_q <= key_mem[rd_addr];
        pay_q <= pay_mem[rd_addr];
    end

    // Control registers.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;    // scan position, then insert/remove slot
    logic [CNT_W-1:0] sh_reg, sh_next;      // entry being written during a shift
    logic             hit_reg, hit_next;
    logic             m_valid_reg, m_valid_next;

    // Item and result registers.
    cmd_t                    cmd_reg, cmd_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [PAYLOAD_W-1:0]    pl_reg, pl_next;
    logic [PAYLOAD_W-1:0]    found_reg, found_next;
    status_t                 status_reg, status_next;
    logic [OUT_TDATA_W-1:0]  m_data_reg, m_data_next;

    // Count widened so that its low seven bits can always be taken.
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign count_ext = {{COUNT_W{1'b0}}, count_reg};
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        sh_next      = sh_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        pl_next      = pl_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        m_data_next  = m_data_reg;

        rd_addr = pos_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = sh_reg[IDX_W-1:0];
        wr_key  = key_q;
        wr_pay  = pay_q;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tdata[1:0];
                    key_next   = $signed(s_tdata[33:2]);
                    pl_next    = s_tdata[65:34];
                    found_next = '0;
                    pos_next   = '0;
                    hit_next   = 1'b0;
                    state_next = (count_reg == '0) ? S_DECIDE : S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                rd_addr    = pos_reg[IDX_W-1:0];
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (key_q < key_reg)
                begin
                    // Stored key is smaller: step on, or stop past the last record.
                    pos_next   = CNT_W'(pos_reg + 1'b1);
                    state_next = (CNT_W'(pos_reg + 1'b1) == count_reg) ? S_DECIDE
                                                                       : S_SCAN_RD;
                end
                else
                begin
                    hit_next   = (key_q == key_reg);
                    found_next = pay_q;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                status_next = ST_MISS;
                state_next  = S_DONE;
                if (!(hit_reg && cmd_reg == CMD_LOOKUP))
                begin
                    found_next = '0;
                end
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            status_next = ST_DUP;
                        end
                        else if (count_reg >= CAP_CNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            // Open a slot at pos by moving the tail up one entry.
                            sh_next    = count_reg;
                            state_next = (count_reg == pos_reg) ? S_PUT : S_SHIFT_RD;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            sh_next = pos_reg;
                            if (CNT_W'(pos_reg + 1'b1) == count_reg)
                            begin
                                count_next  = CNT_W'(count_reg - 1'b1);
                                status_next = ST_OK;
                            end
                            else
                            begin
                                state_next = S_SHIFT_RD;
                            end
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (hit_reg)
                        begin
                            status_next = ST_OK;
                        end
                    end
                    default:
                    begin
                        status_next = ST_MISS;
                    end
                endcase
            end
            S_SHIFT_RD:
            begin
                // Insert pulls from the entry below, remove from the entry above.
                if (cmd_reg == CMD_INSERT)
                begin
                    rd_addr = IDX_W'(sh_reg - 1'b1);
                end
                else
                begin
                    rd_addr = IDX_W'(sh_reg + 1'b1);
                end
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = sh_reg[IDX_W-1:0];
                if (cmd_reg == CMD_INSERT)
                begin
                    sh_next    = CNT_W'(sh_reg - 1'b1);
                    state_next = (CNT_W'(sh_reg - 1'b1) == pos_reg) ? S_PUT : S_SHIFT_RD;
                end
                else
                begin
                    sh_next = CNT_W'(sh_reg + 1'b1);
                    if (CNT_W'(sh_reg + 2'd2) == count_reg)
                    begin
                        count_next  = CNT_W'(count_reg - 1'b1);
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
            end
            S_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = pos_reg[IDX_W-1:0];
                wr_key      = key_reg;
                wr_pay      = pl_reg;
                count_next  = CNT_W'(count_reg + 1'b1);
                status_next = ST_OK;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // Post the result once the output register is free.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0, count_ext[COUNT_W-1:0], found_reg, status_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pos_reg     <= '0;
            sh_reg      <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            sh_reg      <= sh_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        pl_reg     <= pl_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    // The table never holds more records than it has room for.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CAP_CNT)
        else $error("record count above capacity");

    // A new record is only placed into a table that still has a free entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUT |-> count_reg < CAP_CNT)
        else $error("insert placed into a full table");

    // During an insert shift the written entry always lies above the slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_WR && cmd_reg == CMD_INSERT) |-> sh_reg > pos_reg)
        else $error("insert shift ran below the insert slot");

    // The decide cycle of a key that is not held leaves the record count as it was.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && !hit_reg) |=> count_reg == $past(count_reg))
        else $error("record count changed without a matching key");
`endif

endmodule
